// ===== rtl/vll_pkg.sv =====
// vll_pkg: shared types and constants of the vertex leg linker
// used by vll_ram users, vertex_leg_linker and vll_checker; no dependencies
package vll_pkg;

  localparam int SITE_COUNT_MAX = 64;
  localparam int SITE_BITS      = $clog2(SITE_COUNT_MAX);
  localparam int COUNT_BITS     = SITE_BITS + 1;
  localparam int LEG_BITS       = 20;

  localparam logic [COUNT_BITS-1:0] SITE_LIMIT       = COUNT_BITS'(SITE_COUNT_MAX);
  localparam logic [COUNT_BITS-1:0] SITE_COUNT_RESET = COUNT_BITS'(64);

  // leg offsets inside one site pair
  localparam logic [LEG_BITS-1:0] LEG_STEP_A_IN  = LEG_BITS'(0);
  localparam logic [LEG_BITS-1:0] LEG_STEP_B_IN  = LEG_BITS'(1);
  localparam logic [LEG_BITS-1:0] LEG_STEP_A_OUT = LEG_BITS'(2);
  localparam logic [LEG_BITS-1:0] LEG_STEP_B_OUT = LEG_BITS'(3);

  // item kinds
  localparam logic KIND_PAIR  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [LEG_BITS-1:0]  leg_base;
    logic [SITE_BITS-1:0] site_a;
    logic [SITE_BITS-1:0] site_b;
  } in_word_t;

  typedef struct packed {
    logic [LEG_BITS-1:0] link_leg_a;
    logic [LEG_BITS-1:0] link_leg_b;
    logic                last_of_run;
  } out_word_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RDB  = 6'b000010,
    ST_WRA  = 6'b000100,
    ST_WRB  = 6'b001000,
    ST_SCAN = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

endpackage

// ===== rtl/vll_ram.sv =====
// vll_ram: generic single-port ram with registered, enabled read
// no dependencies
module vll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/vertex_leg_linker.sv =====
// vertex_leg_linker: top level, builds the linked vertex list word by word
// depends on vll_pkg and vll_ram
//
//   channel | dir | handshake              | word
//   --------+-----+------------------------+---------------------------------
//   cfg     | in  | cfg_valid / cfg_ready  | cfg_data, site_count register
//   in      | in  | in_valid  / in_ready   | in_data  (vll_pkg::in_word_t)
//   out     | out | out_valid / out_ready  | out_data (vll_pkg::out_word_t)
//
// pair word: accept (reading site_a), read site_b, write site_a, write site_b, set by
//   the single port of each leg table; every link waits while out is stalled
// close word: the accept step, a scan step per site walked (min(site_count, 64)
//   sites), an emit step per touched site and an end step, plus output stalls
// in_ready is high only when idle; cfg is always ready
// reset clears touched flags, fsm and walk index and sets site_count to 64; the leg
//   tables need no clearing pass since touched flags gate every use of a read
module vertex_leg_linker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vll_pkg::COUNT_BITS-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vll_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vll_pkg::out_word_t                  out_data
);

  // control state
  vll_pkg::state_t                        state, state_next;
  logic [vll_pkg::SITE_COUNT_MAX-1:0]     site_touched;
  logic [vll_pkg::COUNT_BITS-1:0]         site_count;
  logic [vll_pkg::COUNT_BITS-1:0]         walk_idx;

  // latched pair word
  logic [vll_pkg::LEG_BITS-1:0]           base;
  logic [vll_pkg::SITE_BITS-1:0]          sa, sb;
  logic                                   ta, tb;
  logic [vll_pkg::LEG_BITS-1:0]           la;

  // leg table ports
  logic [vll_pkg::SITE_BITS-1:0]          ram_addr;
  logic                                   first_we, first_re, last_we, last_re;
  logic [vll_pkg::LEG_BITS-1:0]           first_wdata, last_wdata;
  logic [vll_pkg::LEG_BITS-1:0]           first_rdata, last_rdata;

  // output register
  logic                                   out_free, out_load;
  vll_pkg::out_word_t                     out_word_next;

  // close walk helpers
  logic [vll_pkg::COUNT_BITS-1:0]         walk_limit;
  logic [vll_pkg::SITE_BITS-1:0]          walk_site;
  logic                                   walk_live;
  logic [vll_pkg::SITE_COUNT_MAX-1:0]     above_mask;
  logic [vll_pkg::SITE_COUNT_MAX:0]       below_wide;
  logic                                   more_ahead;

  logic accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == vll_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // first and last leg per site
  vll_ram #(.WIDTH(vll_pkg::LEG_BITS), .DEPTH(vll_pkg::SITE_COUNT_MAX)) u_first_ram (
    .clk   (clk),
    .we    (first_we),
    .re    (first_re),
    .addr  (ram_addr),
    .wdata (first_wdata),
    .rdata (first_rdata)
  );

  vll_ram #(.WIDTH(vll_pkg::LEG_BITS), .DEPTH(vll_pkg::SITE_COUNT_MAX)) u_last_ram (
    .clk   (clk),
    .we    (last_we),
    .re    (last_re),
    .addr  (ram_addr),
    .wdata (last_wdata),
    .rdata (last_rdata)
  );

  // close walk bounds: clamp site_count, look ahead for more touched sites
  always_comb begin
    walk_limit = (site_count > vll_pkg::SITE_LIMIT) ? vll_pkg::SITE_LIMIT : site_count;
    walk_site  = walk_idx[vll_pkg::SITE_BITS-1:0];
    walk_live  = (walk_idx < walk_limit);
    above_mask = ({vll_pkg::SITE_COUNT_MAX{1'b1}} << walk_site) << 1;
    below_wide = ({{vll_pkg::SITE_COUNT_MAX{1'b0}}, 1'b1} << walk_limit) - 1'b1;
    more_ahead = |(site_touched & above_mask & below_wide[vll_pkg::SITE_COUNT_MAX-1:0]);
  end

  // sequencer
  always_comb begin
    state_next    = state;
    ram_addr      = sa;
    first_we      = 1'b0;
    first_re      = 1'b0;
    last_we       = 1'b0;
    last_re       = 1'b0;
    first_wdata   = base + vll_pkg::LEG_STEP_A_IN;
    last_wdata    = base + vll_pkg::LEG_STEP_A_OUT;
    out_load      = 1'b0;
    out_word_next = '{link_leg_a: la,
                      link_leg_b: base + vll_pkg::LEG_STEP_A_IN,
                      last_of_run: !tb};
    case (state)
      vll_pkg::ST_IDLE: begin
        // read last leg of site_a straight off the input word
        ram_addr = in_data.site_a;
        if (accept) begin
          if (in_data.kind == vll_pkg::KIND_PAIR) begin
            last_re    = 1'b1;
            state_next = vll_pkg::ST_RDB;
          end else begin
            state_next = vll_pkg::ST_SCAN;
          end
        end
      end
      vll_pkg::ST_RDB: begin
        ram_addr   = sb;
        last_re    = 1'b1;
        state_next = vll_pkg::ST_WRA;
      end
      vll_pkg::ST_WRA: begin
        // link site_a if open, else its first leg is the new leg
        ram_addr = sa;
        if (!ta || out_free) begin
          out_load   = ta;
          first_we   = !ta;
          last_we    = 1'b1;
          state_next = vll_pkg::ST_WRB;
        end
      end
      vll_pkg::ST_WRB: begin
        // last_rdata still holds site_b, read before any write
        ram_addr      = sb;
        first_wdata   = base + vll_pkg::LEG_STEP_B_IN;
        last_wdata    = base + vll_pkg::LEG_STEP_B_OUT;
        out_word_next = '{link_leg_a: last_rdata,
                          link_leg_b: base + vll_pkg::LEG_STEP_B_IN,
                          last_of_run: 1'b1};
        if (!tb || out_free) begin
          out_load   = tb;
          first_we   = !tb;
          last_we    = 1'b1;
          state_next = vll_pkg::ST_IDLE;
        end
      end
      vll_pkg::ST_SCAN: begin
        ram_addr = walk_site;
        if (!walk_live) begin
          state_next = vll_pkg::ST_IDLE;
        end else if (site_touched[walk_site]) begin
          first_re   = 1'b1;
          last_re    = 1'b1;
          state_next = vll_pkg::ST_EMIT;
        end
      end
      vll_pkg::ST_EMIT: begin
        // periodic link last -> first
        ram_addr      = walk_site;
        out_word_next = '{link_leg_a: last_rdata,
                          link_leg_b: first_rdata,
                          last_of_run: !more_ahead};
        if (out_free) begin
          out_load   = 1'b1;
          state_next = vll_pkg::ST_SCAN;
        end
      end
      default: begin
        state_next = vll_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= vll_pkg::ST_IDLE;
      site_touched <= '0;
      site_count   <= vll_pkg::SITE_COUNT_RESET;
      walk_idx     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        site_count <= cfg_data;
      end
      if (state == vll_pkg::ST_WRA && state_next == vll_pkg::ST_WRB) begin
        site_touched[sa] <= 1'b1;
      end
      if (state == vll_pkg::ST_WRB && state_next == vll_pkg::ST_IDLE) begin
        site_touched[sb] <= 1'b1;
      end
      // walk: step past untouched sites, or after the link is taken
      if (state == vll_pkg::ST_SCAN) begin
        if (!walk_live) begin
          walk_idx     <= '0;
          site_touched <= '0;
        end else if (!site_touched[walk_site]) begin
          walk_idx <= walk_idx + 1'b1;
        end
      end
      if (state == vll_pkg::ST_EMIT && out_free) begin
        walk_idx <= walk_idx + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      base <= in_data.leg_base;
      sa   <= in_data.site_a;
      sb   <= in_data.site_b;
      ta   <= site_touched[in_data.site_a];
      tb   <= site_touched[in_data.site_b];
    end
    if (state == vll_pkg::ST_RDB) begin
      la <= last_rdata;
    end
    if (out_load) begin
      out_data <= out_word_next;
    end
  end

endmodule

// ===== rtl/vll_checker.sv =====
// vll_checker: port-level assertions on vertex_leg_linker, bound to the top level
// depends on vll_pkg and vertex_leg_linker
module vll_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [vll_pkg::COUNT_BITS-1:0] cfg_data,
  input logic                           in_valid,
  input logic                           in_ready,
  input vll_pkg::in_word_t              in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input vll_pkg::out_word_t             out_data
);

  // no result word survives reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after accept");

  // results only come out of work in progress, never from idle
  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word raised while idle");

endmodule

bind vertex_leg_linker vll_checker u_vll_checker (.*);
